[rtl/uset_pkg.sv]
package uset_pkg;

  localparam int VAL_W        = 31;
  localparam int STAT_W       = 3;
  localparam int DEF_CAPACITY = 16;
  localparam int QDEPTH       = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEARCH,
    B_SHIFT
  } bstate_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
  } item_t;

endpackage

[rtl/uset_front.sv]
module uset_front
  import uset_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_cmd,
  input  logic [VAL_W-1:0] in_value,
  output logic             q_vld,
  output item_t            q_item,
  input  logic             q_pop
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW   = $clog2(QDEPTH + 1);

  item_t            q_r [QDEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [QCW-1:0]   qc_r, qc_nxt;
  logic             push;
  item_t            push_item;

  // decode the command bit into an operation code
  always_comb begin
    push_item.value = in_value;
    unique case (in_cmd)
      1'b0:    push_item.op = OP_INSERT;
      default: push_item.op = OP_DELETE;
    endcase
  end

  assign busy   = (qc_r == QCW'(QDEPTH));
  assign push   = start && !busy;
  assign q_vld  = (qc_r != '0);
  assign q_item = q_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    qc_nxt = qc_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(QDEPTH - 1)) ? '0 : PTR_W'(wp_r + 1'b1);
    end
    if (q_pop && q_vld) begin
      rp_nxt = (rp_r == PTR_W'(QDEPTH - 1)) ? '0 : PTR_W'(rp_r + 1'b1);
    end
    if (push && !(q_pop && q_vld)) begin
      qc_nxt = QCW'(qc_r + 1'b1);
    end else if (!push && (q_pop && q_vld)) begin
      qc_nxt = QCW'(qc_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      qc_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      qc_r <= qc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_item;
    end
  end

endmodule

[rtl/uset_back.sv]
module uset_back
  import uset_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_vld,
  input  item_t                            q_item,
  output logic                             q_pop,
  output logic                             out_strobe,
  output logic [STAT_W-1:0]                out_status,
  output logic [$clog2(CAPACITY+1)-1:0]    out_slot,
  output logic [$clog2(CAPACITY+1)-1:0]    out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // entry store, packed in arrival order
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_q_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [VAL_W-1:0] mem_wd;

  bstate_t          state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             chk_r, chk_nxt;
  logic [CNT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             wpend_r, wpend_nxt;
  logic [IDX_W-1:0] wadr_r, wadr_nxt;
  logic             o_vld_r, o_vld_nxt;
  status_t          o_stat_r, o_stat_nxt;
  logic [CNT_W-1:0] o_slot_r, o_slot_nxt;
  logic [CNT_W-1:0] o_cnt_r, o_cnt_nxt;

  logic             hit, miss, srch_done, del_go;
  logic [CNT_W-1:0] ptr_inc;
  logic             shift_more, shift_done;

  assign hit        = chk_r && (rd_q_r == val_r);
  assign miss       = !chk_r && (ptr_r >= cnt_r);
  assign srch_done  = hit || miss;
  assign del_go     = hit && (op_r == OP_DELETE);
  assign ptr_inc    = CNT_W'(ptr_r + 1'b1);
  assign shift_more = (ptr_inc < cnt_r);
  assign shift_done = !shift_more && !wpend_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (q_vld) state_nxt = B_SEARCH;
      B_SEARCH: if (srch_done) state_nxt = del_go ? B_SHIFT : B_IDLE;
      B_SHIFT:  if (shift_done) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop       = 1'b0;
    op_nxt      = op_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    ptr_nxt     = ptr_r;
    chk_nxt     = 1'b0;
    chk_idx_nxt = chk_idx_r;
    pos_nxt     = pos_r;
    wpend_nxt   = 1'b0;
    wadr_nxt    = wadr_r;
    rd_en       = 1'b0;
    rd_addr     = ptr_r[IDX_W-1:0];
    mem_we      = 1'b0;
    mem_wa      = cnt_r[IDX_W-1:0];
    mem_wd      = val_r;
    o_vld_nxt   = 1'b0;
    o_stat_nxt  = o_stat_r;
    o_slot_nxt  = o_slot_r;
    o_cnt_nxt   = o_cnt_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_vld) begin
          q_pop   = 1'b1;
          op_nxt  = q_item.op;
          val_nxt = q_item.value;
          ptr_nxt = '0;
        end
      end
      B_SEARCH: begin
        if (srch_done) begin
          o_vld_nxt = !del_go;
          if (op_r == OP_INSERT) begin
            if (hit) begin
              o_stat_nxt = ST_PRESENT;
              o_slot_nxt = chk_idx_r;
            end else if (cnt_r >= CNT_W'(CAPACITY)) begin
              o_stat_nxt = ST_FULL;
              o_slot_nxt = cnt_r;
            end else begin
              mem_we     = 1'b1;
              cnt_nxt    = CNT_W'(cnt_r + 1'b1);
              o_stat_nxt = ST_INSERTED;
              o_slot_nxt = cnt_r;
            end
          end else begin
            if (hit) begin
              pos_nxt = chk_idx_r;
              ptr_nxt = chk_idx_r;
            end else begin
              o_stat_nxt = ST_NOT_FOUND;
              o_slot_nxt = cnt_r;
            end
          end
          o_cnt_nxt = cnt_nxt;
        end else if (ptr_r < cnt_r) begin
          // issue the next compare; the read data returns in the next cycle
          rd_en       = 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = ptr_r;
          ptr_nxt     = ptr_inc;
        end
      end
      B_SHIFT: begin
        if (wpend_r) begin
          mem_we = 1'b1;
          mem_wa = wadr_r;
          mem_wd = rd_q_r;
        end
        if (shift_more) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_inc[IDX_W-1:0];
          wpend_nxt = 1'b1;
          wadr_nxt  = ptr_r[IDX_W-1:0];
          ptr_nxt   = ptr_inc;
        end else if (!wpend_r) begin
          cnt_nxt    = CNT_W'(cnt_r - 1'b1);
          o_vld_nxt  = 1'b1;
          o_stat_nxt = ST_DELETED;
          o_slot_nxt = pos_r;
          o_cnt_nxt  = CNT_W'(cnt_r - 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r   <= '0;
      chk_r   <= 1'b0;
      wpend_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chk_r   <= chk_nxt;
      wpend_r <= wpend_nxt;
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    ptr_r     <= ptr_nxt;
    chk_idx_r <= chk_idx_nxt;
    pos_r     <= pos_nxt;
    wadr_r    <= wadr_nxt;
    o_stat_r  <= o_stat_nxt;
    o_slot_r  <= o_slot_nxt;
    o_cnt_r   <= o_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign out_strobe      = o_vld_r;
  assign out_status      = o_stat_r;
  assign out_slot        = o_slot_r;
  assign out_entry_count = o_cnt_r;

endmodule

[rtl/unordered_set_table_insert_delete_core.sv]
// Channel   Ports                                        Handshake
// -------   -------------------------------------------  ------------------------------
// input     in_cmd, in_value                             taken when start && !busy
// result    out_status, out_slot, out_entry_count        one cycle, marked by out_strobe
//
// Flow: the engine pops an item, then compares the held entries in order and stops at a
// hit or after the last entry; an empty table misses at once. A delete hit then shifts
// every later entry down by one slot. The engine takes no new item until the last is done.
// Reset: synchronous active-low rst_n empties the table and the item queue.
// Stalls: busy rises only when the two-item queue is full; the receiver cannot stall.
module unordered_set_table_insert_delete_core
  import uset_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [VAL_W-1:0]              in_value,
  output logic                          out_strobe,
  output logic [STAT_W-1:0]             out_status,
  output logic [$clog2(CAPACITY+1)-1:0] out_slot,
  output logic [$clog2(CAPACITY+1)-1:0] out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // item handoff from front to engine
  logic  q_vld;
  item_t q_item;
  logic  q_pop;

  // front: decodes the command and queues items
  uset_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_cmd   (in_cmd),
    .in_value (in_value),
    .q_vld    (q_vld),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // engine: linear search, append, shift-down delete
  uset_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_vld           (q_vld),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_entry_count (out_entry_count)
  );

  // a result strobe is never directly followed by another
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  // a successful insert lands at the old end of the table
  a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_INSERTED) |->
      (out_entry_count == CNT_W'(out_slot + 1'b1)))
    else $error("insert slot and count disagree");

  // a full refusal only when the table is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |->
      (out_entry_count == CNT_W'(CAPACITY) && out_slot == CNT_W'(CAPACITY)))
    else $error("full reported below capacity");

  // a delete reports a slot inside the table as it was
  a_delete_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_DELETED) |-> (out_slot <= out_entry_count))
    else $error("delete slot beyond table");

endmodule
